// ===== design/kvrt_pkg.sv =====
// ----------------------------------------------------------------------------
// Key/value record tokenizer package
// Shared types, constants and separator matching helpers.
// ----------------------------------------------------------------------------
package kvrt_pkg;

  localparam int DEF_MAX_SEP_LEN     = 4;
  localparam int DEF_PAIR_INDEX_BITS = 16;
  localparam int WIN_DEPTH           = 4;
  localparam int NUM_RES             = 6;

  localparam logic [7:0] CR_BYTE = 8'h0D;
  localparam logic [7:0] LF_BYTE = 8'h0A;

  localparam logic [2:0] REG_RECORD_SEP = 3'd0;
  localparam logic [2:0] REG_FIELD_SEP  = 3'd1;
  localparam logic [2:0] REG_PAIR_SEP   = 3'd2;
  localparam logic [2:0] REG_COMMENT    = 3'd3;
  localparam logic [2:0] REG_SEP_LENS   = 3'd4;
  localparam logic [2:0] REG_MODE       = 3'd5;

  localparam logic [1:0] TOK_KEY      = 2'd0;
  localparam logic [1:0] TOK_VALUE    = 2'd1;
  localparam logic [1:0] TOK_PAIR_END = 2'd2;
  localparam logic [1:0] TOK_REC_END  = 2'd3;

  localparam logic [1:0] LE_NONE = 2'd0;
  localparam logic [1:0] LE_LF   = 2'd1;
  localparam logic [1:0] LE_CRLF = 2'd2;

  typedef enum logic [3:0] {
    PH_RECORD_START = 4'b0001,
    PH_COMMENT      = 4'b0010,
    PH_PAIR_START   = 4'b0100,
    PH_BODY         = 4'b1000
  } phase_e;

  typedef enum logic [1:0] {
    ST_NO    = 2'd0,
    ST_MATCH = 2'd1,
    ST_WAIT  = 2'd2
  } match_e;

  typedef struct packed {
    logic [31:0] record_sep;
    logic [31:0] field_sep;
    logic [31:0] pair_sep;
    logic [31:0] comment;
    logic [11:0] lens;
    logic [1:0]  mode;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  text_byte;
    logic [15:0] pos;
    logic        use_pos;
    logic [1:0]  le;
    logic        last;
  } res_t;

  typedef struct packed {
    res_t [NUM_RES-1:0] items;
    logic [2:0]         cnt;
  } batch_t;

  typedef struct packed {
    logic [WIN_DEPTH-1:0][7:0] win;
    logic [2:0]                fill;
    logic [7:0]                last;
  } cons_t;

  function automatic match_e sep_match(logic [WIN_DEPTH-1:0][7:0] w, logic [2:0] f,
                                       logic [31:0] bytes, logic [2:0] len, logic eod);
    logic [2:0] n;
    logic       mis;
    match_e     s;
    n   = (f < len) ? f : len;
    mis = 1'b0;
    for (int i = 0; i < WIN_DEPTH; i++) begin
      if ((3'(i) < n) && (w[i] != bytes[8*i +: 8])) begin
        mis = 1'b1;
      end
    end
    if (len == 3'd0 || mis) begin
      s = ST_NO;
    end else if (f >= len) begin
      s = ST_MATCH;
    end else begin
      s = eod ? ST_NO : ST_WAIT;
    end
    return s;
  endfunction

  function automatic cons_t consume(logic [WIN_DEPTH-1:0][7:0] w, logic [2:0] f,
                                    logic [2:0] n);
    cons_t      c;
    logic [2:0] k;
    k      = (n == 3'd0 || n > f) ? f : n;
    c.win  = '0;
    c.fill = f - k;
    c.last = 8'h00;
    if (k != 3'd0) begin
      c.last = w[2'(k - 3'd1)];
    end
    for (int i = 0; i < WIN_DEPTH; i++) begin
      if (i + int'(k) < WIN_DEPTH) begin
        c.win[i] = w[2'(i + int'(k))];
      end
    end
    return c;
  endfunction

  function automatic res_t text_res(logic ps_seen, logic [7:0] b);
    res_t r;
    r           = '0;
    r.kind      = ps_seen ? TOK_VALUE : TOK_KEY;
    r.text_byte = b;
    return r;
  endfunction

endpackage

// ===== design/kvrt_if.sv =====
// ----------------------------------------------------------------------------
// Key/value record tokenizer channels
// Valid/ready channels for input bytes and result tokens.
// ----------------------------------------------------------------------------
interface kvrt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_data;

  modport source (output valid, data_byte, end_of_data, input ready);
  modport sink (input valid, data_byte, end_of_data, output ready);
endinterface

interface kvrt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  token_kind;
  logic [7:0]  text_byte;
  logic [15:0] pair_position;
  logic        use_position_key;
  logic [1:0]  line_ending;
  logic        last_result;

  modport source (output valid, token_kind, text_byte, pair_position, use_position_key,
                  line_ending, last_result, input ready);
  modport sink (input valid, token_kind, text_byte, pair_position, use_position_key,
                line_ending, last_result, output ready);
endinterface

// ===== design/kvrt_cfg.sv =====
// ----------------------------------------------------------------------------
// Key/value record tokenizer configuration registers
// Holds the separators, their lengths and the mode flags.
// ----------------------------------------------------------------------------
module kvrt_cfg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_idx_i,
  input  logic [31:0]   cfg_wdata_i,
  output kvrt_pkg::cfg_t cfg_o
);
  import kvrt_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_RECORD_SEP: cfg_d.record_sep = cfg_wdata_i;
        REG_FIELD_SEP:  cfg_d.field_sep  = cfg_wdata_i;
        REG_PAIR_SEP:   cfg_d.pair_sep   = cfg_wdata_i;
        REG_COMMENT:    cfg_d.comment    = cfg_wdata_i;
        REG_SEP_LENS:   cfg_d.lens       = cfg_wdata_i[11:0];
        REG_MODE:       cfg_d.mode       = cfg_wdata_i[1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.record_sep <= 32'd10;
      cfg_q.field_sep  <= 32'd44;
      cfg_q.pair_sep   <= 32'd61;
      cfg_q.comment    <= 32'd0;
      cfg_q.lens       <= 12'd73;
      cfg_q.mode       <= 2'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/kvrt_parse.sv =====
// ----------------------------------------------------------------------------
// Key/value record tokenizer parser
// Input register, parse state and the single-pass step that turns one byte
// into a batch of result tokens.
// ----------------------------------------------------------------------------
module kvrt_parse #(
  parameter int MAX_SEP_LEN     = kvrt_pkg::DEF_MAX_SEP_LEN,
  parameter int PAIR_INDEX_BITS = kvrt_pkg::DEF_PAIR_INDEX_BITS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  kvrt_in_if.sink          in_i,
  input  kvrt_pkg::cfg_t   cfg_i,
  input  logic             buf_free_i,
  output logic             load_o,
  output kvrt_pkg::batch_t batch_o
);
  import kvrt_pkg::*;

  localparam int SepLimit = (MAX_SEP_LEN < WIN_DEPTH) ? MAX_SEP_LEN : WIN_DEPTH;

  logic                      in_valid_q;
  logic [7:0]                byte_q;
  logic                      eod_q;
  logic [WIN_DEPTH-1:0][7:0] win_q, win_d;
  logic [2:0]                fill_q, fill_d;
  phase_e                    phase_q, phase_d;
  logic                      ps_q, ps_d, ks_q, ks_d, vs_q, vs_d;
  logic                      hcr_q, hcr_d, lcr_q, lcr_d;
  logic [PAIR_INDEX_BITS-1:0] pc_q, pc_d;

  logic        collapse, autole;
  logic [31:0] rs_bytes;
  logic [2:0]  rs_len, fs_len, ps_len, cm_len;

  function automatic logic [2:0] sep_len(logic [2:0] l);
    return (l > 3'(SepLimit)) ? 3'(SepLimit) : l;
  endfunction

  function automatic logic [15:0] sat16(logic [PAIR_INDEX_BITS-1:0] p);
    return (32'(p) > 32'd65535) ? 16'hFFFF : 16'(p);
  endfunction

  function automatic logic [PAIR_INDEX_BITS-1:0] next_pos(logic [PAIR_INDEX_BITS-1:0] p);
    return (p == '1) ? p : p + 1'b1;
  endfunction

  assign collapse = cfg_i.mode[0];
  assign autole   = cfg_i.mode[1];
  assign rs_bytes = autole ? 32'(LF_BYTE) : cfg_i.record_sep;
  assign rs_len   = autole ? 3'd1 : sep_len(cfg_i.lens[2:0]);
  assign fs_len   = sep_len(cfg_i.lens[5:3]);
  assign ps_len   = sep_len(cfg_i.lens[8:6]);
  assign cm_len   = sep_len(cfg_i.lens[11:9]);

  assign load_o     = in_valid_q && buf_free_i;
  assign in_i.ready = !in_valid_q || buf_free_i;

  always_comb begin : step
    logic [WIN_DEPTH-1:0][7:0] w;
    logic [2:0]                f;
    phase_e                    ph;
    logic                      ps, ks, vs, hcr, lcr, stop, fin, v0, v1, drop;
    logic [PAIR_INDEX_BITS-1:0] pc, np;
    match_e                    s;
    cons_t                     c;
    res_t                      em0, em1;
    logic [7:0]                b;
    batch_t                    bt;

    w   = win_q;
    f   = fill_q;
    ph  = phase_q;
    ps  = ps_q;
    ks  = ks_q;
    vs  = vs_q;
    hcr = hcr_q;
    lcr = lcr_q;
    pc  = pc_q;
    bt  = '0;
    stop = 1'b0;
    fin  = 1'b0;
    drop = 1'b0;
    np   = '0;
    s    = ST_NO;
    c    = '0;
    b    = 8'h00;

    if (f < 3'(WIN_DEPTH)) begin
      w[f[1:0]] = byte_q;
      f         = f + 3'd1;
    end

    for (int it = 0; it < WIN_DEPTH; it++) begin
      v0  = 1'b0;
      v1  = 1'b0;
      em0 = '0;
      em1 = '0;
      if (!stop && f != 3'd0) begin
        fin = 1'b0;
        if (ph == PH_RECORD_START) begin
          lcr = 1'b0;
          hcr = 1'b0;
          s   = sep_match(w, f, cfg_i.comment, cm_len, eod_q);
          if (s == ST_MATCH) begin
            c   = consume(w, f, cm_len);
            w   = c.win;
            f   = c.fill;
            ph  = PH_COMMENT;
            fin = 1'b1;
          end else if (s == ST_WAIT) begin
            stop = 1'b1;
            fin  = 1'b1;
          end else begin
            ph = collapse ? PH_PAIR_START : PH_BODY;
          end
        end
        if (!fin && ph == PH_COMMENT) begin
          fin = 1'b1;
          s   = sep_match(w, f, rs_bytes, rs_len, eod_q);
          if (s == ST_MATCH) begin
            c  = consume(w, f, rs_len);
            w  = c.win;
            f  = c.fill;
            ph = PH_RECORD_START;
          end else if (s == ST_WAIT) begin
            stop = 1'b1;
          end else begin
            c = consume(w, f, 3'd1);
            w = c.win;
            f = c.fill;
          end
        end
        if (!fin && ph == PH_PAIR_START) begin
          s = sep_match(w, f, cfg_i.field_sep, fs_len, eod_q);
          if (s == ST_MATCH) begin
            c   = consume(w, f, fs_len);
            w   = c.win;
            f   = c.fill;
            lcr = (c.last == CR_BYTE);
            fin = 1'b1;
          end else if (s == ST_WAIT) begin
            stop = 1'b1;
            fin  = 1'b1;
          end else begin
            ph = PH_BODY;
          end
        end
        if (!fin && ph == PH_BODY) begin
          s = sep_match(w, f, rs_bytes, rs_len, eod_q);
          if (s == ST_MATCH) begin
            c           = consume(w, f, rs_len);
            w           = c.win;
            f           = c.fill;
            np          = next_pos(pc);
            drop        = collapse && !ks && (!ps || !vs);
            v1          = 1'b1;
            em1.kind    = TOK_REC_END;
            em1.pos     = drop ? 16'd0 : sat16(np);
            em1.use_pos = !drop && (!ks || !ps);
            em1.le      = autole ? (lcr ? LE_CRLF : LE_LF) : LE_NONE;
            ps  = 1'b0;
            ks  = 1'b0;
            vs  = 1'b0;
            pc  = '0;
            hcr = 1'b0;
            lcr = 1'b0;
            ph  = PH_RECORD_START;
          end else if (s == ST_WAIT) begin
            stop = 1'b1;
          end else begin
            s = sep_match(w, f, cfg_i.field_sep, fs_len, eod_q);
            if (s == ST_MATCH) begin
              np = next_pos(pc);
              if (hcr) begin
                v0  = 1'b1;
                em0 = text_res(ps, CR_BYTE);
                if (ps) vs = 1'b1;
                else ks = 1'b1;
                hcr = 1'b0;
              end
              c           = consume(w, f, fs_len);
              w           = c.win;
              f           = c.fill;
              lcr         = (c.last == CR_BYTE);
              v1          = 1'b1;
              em1.kind    = TOK_PAIR_END;
              em1.pos     = sat16(np);
              em1.use_pos = !ks || !ps;
              pc  = np;
              ps  = 1'b0;
              ks  = 1'b0;
              vs  = 1'b0;
              ph  = collapse ? PH_PAIR_START : PH_BODY;
            end else if (s == ST_WAIT) begin
              stop = 1'b1;
            end else begin
              s = ps ? ST_NO : sep_match(w, f, cfg_i.pair_sep, ps_len, eod_q);
              if (s == ST_MATCH) begin
                if (hcr) begin
                  v0  = 1'b1;
                  em0 = text_res(ps, CR_BYTE);
                  ks  = 1'b1;
                  hcr = 1'b0;
                end
                c   = consume(w, f, ps_len);
                w   = c.win;
                f   = c.fill;
                lcr = (c.last == CR_BYTE);
                ps  = 1'b1;
              end else if (s == ST_WAIT) begin
                stop = 1'b1;
              end else begin
                c = consume(w, f, 3'd1);
                w = c.win;
                f = c.fill;
                b = c.last;
                if (hcr) begin
                  v0  = 1'b1;
                  em0 = text_res(ps, CR_BYTE);
                  if (ps) vs = 1'b1;
                  else ks = 1'b1;
                  hcr = 1'b0;
                end
                if (autole && b == CR_BYTE) begin
                  hcr = 1'b1;
                end else begin
                  v1  = 1'b1;
                  em1 = text_res(ps, b);
                  if (ps) vs = 1'b1;
                  else ks = 1'b1;
                end
                lcr = (b == CR_BYTE);
              end
            end
          end
        end
        if (v0 && bt.cnt < 3'(NUM_RES)) begin
          bt.items[bt.cnt] = em0;
          bt.cnt           = bt.cnt + 3'd1;
        end
        if (v1 && bt.cnt < 3'(NUM_RES)) begin
          bt.items[bt.cnt] = em1;
          bt.cnt           = bt.cnt + 3'd1;
        end
      end
    end

    if (eod_q) begin
      v0  = 1'b0;
      v1  = 1'b0;
      em0 = '0;
      em1 = '0;
      if (ph == PH_PAIR_START || ph == PH_BODY) begin
        if (hcr) begin
          v0  = 1'b1;
          em0 = text_res(ps, CR_BYTE);
          if (ps) vs = 1'b1;
          else ks = 1'b1;
        end
        np          = next_pos(pc);
        drop        = collapse && !ks && (!ps || !vs);
        v1          = 1'b1;
        em1.kind    = TOK_REC_END;
        em1.pos     = drop ? 16'd0 : sat16(np);
        em1.use_pos = !drop && (!ks || !ps);
        em1.le      = LE_NONE;
      end
      if (v0 && bt.cnt < 3'(NUM_RES)) begin
        bt.items[bt.cnt] = em0;
        bt.cnt           = bt.cnt + 3'd1;
      end
      if (v1 && bt.cnt < 3'(NUM_RES)) begin
        bt.items[bt.cnt] = em1;
        bt.cnt           = bt.cnt + 3'd1;
      end
      w   = '0;
      f   = 3'd0;
      ph  = PH_RECORD_START;
      ps  = 1'b0;
      ks  = 1'b0;
      vs  = 1'b0;
      pc  = '0;
      hcr = 1'b0;
      lcr = 1'b0;
    end

    if (bt.cnt != 3'd0) begin
      bt.items[bt.cnt - 3'd1].last = 1'b1;
    end

    win_d   = w;
    fill_d  = f;
    phase_d = ph;
    ps_d    = ps;
    ks_d    = ks;
    vs_d    = vs;
    hcr_d   = hcr;
    lcr_d   = lcr;
    pc_d    = pc;
    batch_o = bt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      win_q      <= '0;
      fill_q     <= 3'd0;
      phase_q    <= PH_RECORD_START;
      ps_q       <= 1'b0;
      ks_q       <= 1'b0;
      vs_q       <= 1'b0;
      hcr_q      <= 1'b0;
      lcr_q      <= 1'b0;
      pc_q       <= '0;
    end else begin
      if (in_i.valid && in_i.ready) begin
        in_valid_q <= 1'b1;
      end else if (load_o) begin
        in_valid_q <= 1'b0;
      end
      if (load_o) begin
        win_q   <= win_d;
        fill_q  <= fill_d;
        phase_q <= phase_d;
        ps_q    <= ps_d;
        ks_q    <= ks_d;
        vs_q    <= vs_d;
        hcr_q   <= hcr_d;
        lcr_q   <= lcr_d;
        pc_q    <= pc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      byte_q <= in_i.data_byte;
      eod_q  <= in_i.end_of_data;
    end
  end

endmodule

// ===== design/kvrt_outbuf.sv =====
// ----------------------------------------------------------------------------
// Key/value record tokenizer result buffer
// Holds the tokens of one byte and hands them out one transaction at a time.
// ----------------------------------------------------------------------------
module kvrt_outbuf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  kvrt_pkg::batch_t batch_i,
  output logic             free_o,
  kvrt_out_if.source       out_o
);
  import kvrt_pkg::*;

  res_t [NUM_RES-1:0] items_q;
  logic [2:0]         cnt_q, rd_q;
  res_t               cur;

  assign out_o.valid = (rd_q != cnt_q);
  assign free_o      = (rd_q == cnt_q) || (out_o.ready && (rd_q + 3'd1 == cnt_q));
  assign cur         = items_q[rd_q];

  assign out_o.token_kind       = cur.kind;
  assign out_o.text_byte        = cur.text_byte;
  assign out_o.pair_position    = cur.pos;
  assign out_o.use_position_key = cur.use_pos;
  assign out_o.line_ending      = cur.le;
  assign out_o.last_result      = cur.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 3'd0;
      rd_q  <= 3'd0;
    end else if (load_i) begin
      cnt_q <= batch_i.cnt;
      rd_q  <= 3'd0;
    end else if (out_o.valid && out_o.ready) begin
      rd_q <= rd_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      items_q <= batch_i.items;
    end
  end

endmodule

// ===== design/key_value_record_tokenizer_core.sv =====
// ----------------------------------------------------------------------------
// Key/value record tokenizer core
// Splits a byte stream into records and key/value pairs and emits tokens.
// ----------------------------------------------------------------------------
// The first token of a byte is offered once the byte has passed the input
// register and been loaded into the result buffer, which waits until free.
// Throughput: one byte per cycle while each byte yields at most one token and
// out_o is ready; a byte with more tokens holds the buffer until all are taken.
// Reset: asynchronous, active low; registers take their default values and
// parsing restarts at record start.
module key_value_record_tokenizer_core #(
  parameter int MAX_SEP_LEN     = kvrt_pkg::DEF_MAX_SEP_LEN,
  parameter int PAIR_INDEX_BITS = kvrt_pkg::DEF_PAIR_INDEX_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  kvrt_in_if.sink     in_i,
  kvrt_out_if.source  out_o
);
  import kvrt_pkg::*;

  cfg_t   cfg;
  logic   buf_free;
  logic   load;
  batch_t batch;

  kvrt_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  kvrt_parse #(
    .MAX_SEP_LEN     (MAX_SEP_LEN),
    .PAIR_INDEX_BITS (PAIR_INDEX_BITS)
  ) u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .cfg_i      (cfg),
    .buf_free_i (buf_free),
    .load_o     (load),
    .batch_o    (batch)
  );

  kvrt_outbuf u_outbuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (load),
    .batch_i (batch),
    .free_o  (buf_free),
    .out_o   (out_o)
  );

endmodule

// ===== tb/sv/key_value_record_tokenizer_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Key/value record tokenizer core testbench
// Feeds byte streams under several separator and mode settings, predicts the
// token stream in the testbench and checks every token field by field while
// both channels idle and stall at random.
// ----------------------------------------------------------------------------
module key_value_record_tokenizer_core_test;
  import kvrt_pkg::*;

  typedef struct {
    logic [7:0] b;
    logic       eod;
    bit         hold;
  } byte_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = REG_RECORD_SEP;
  logic [31:0] cfg_wdata_i = '0;

  kvrt_in_if  in_ch ();
  kvrt_out_if out_ch ();

  key_value_record_tokenizer_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  always #4 clk_i = ~clk_i;

  byte_item_t pending_bytes[$];
  res_t       expected_tokens[$];
  int         err_count = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         tokens_checked = 0;
  int         bytes_sent = 0;
  int         quiet_cycles = 0;

  // Predictor configuration copy.
  logic [31:0] c_rs = 32'd10, c_fs = 32'd44, c_ps = 32'd61, c_cm = 32'd0;
  logic [11:0] c_len = 12'd73;
  logic [1:0]  c_mode = 2'd0;

  // Predictor state.
  logic [7:0]  win [4];
  int          fill;
  phase_e      ph;
  bit          kv_sep, key_seen, val_seen, cr_held, cr_last;
  int unsigned pairs;

  function automatic int clamp_len(int sh);
    int l;
    l = (c_len >> sh) & 7;
    return (l > 4) ? 4 : l;
  endfunction

  function automatic match_e sep_state(logic [31:0] bytes, int len, bit eod);
    int n;
    if (len == 0) return ST_NO;
    n = (fill < len) ? fill : len;
    for (int i = 0; i < n; i++) begin
      if (win[i] != bytes[8*i +: 8]) return ST_NO;
    end
    if (fill >= len) return ST_MATCH;
    return eod ? ST_NO : ST_WAIT;
  endfunction

  function automatic logic [7:0] take_bytes(int n);
    logic [7:0] lastb;
    if (n == 0 || n > fill) n = fill;
    if (n == 0) return 8'h00;
    lastb = win[n-1];
    for (int i = 0; i < 4; i++) begin
      win[i] = (i + n < 4) ? win[i+n] : 8'h00;
    end
    fill -= n;
    return lastb;
  endfunction

  function automatic void push_token(logic [1:0] kind, logic [7:0] b, int unsigned pos,
                                     bit use_pos, logic [1:0] le);
    res_t t;
    t = '0;
    t.kind = kind;
    t.text_byte = b;
    t.pos = (pos > 65535) ? 16'hFFFF : pos[15:0];
    t.use_pos = use_pos;
    t.le = le;
    expected_tokens.push_back(t);
  endfunction

  function automatic int unsigned next_pos();
    return (pairs >= 65535) ? 65535 : pairs + 1;
  endfunction

  function automatic void text_token(logic [7:0] b);
    if (kv_sep) begin
      val_seen = 1;
      push_token(TOK_VALUE, b, 0, 1'b0, LE_NONE);
    end else begin
      key_seen = 1;
      push_token(TOK_KEY, b, 0, 1'b0, LE_NONE);
    end
  endfunction

  function automatic void flush_cr();
    if (cr_held) begin
      cr_held = 0;
      text_token(CR_BYTE);
    end
  endfunction

  function automatic void clear_pair();
    kv_sep = 0;
    key_seen = 0;
    val_seen = 0;
  endfunction

  function automatic void close_record(logic [1:0] le);
    bit drop;
    drop = c_mode[0] && !key_seen && (!kv_sep || !val_seen);
    push_token(TOK_REC_END, 8'h00, drop ? 0 : next_pos(),
               drop ? 1'b0 : (!key_seen || !kv_sep), le);
    clear_pair();
    pairs = 0;
    cr_held = 0;
    cr_last = 0;
    ph = PH_RECORD_START;
  endfunction

  function automatic void reset_parse();
    for (int i = 0; i < 4; i++) win[i] = 8'h00;
    fill = 0;
    ph = PH_RECORD_START;
    clear_pair();
    pairs = 0;
    cr_held = 0;
    cr_last = 0;
  endfunction

  function automatic void predict_tokens(logic [7:0] din, bit eod);
    int          base, rs_len, fs_len, ps_len, cm_len;
    bit          waiting, done, autole, collapse;
    logic [31:0] rs_bytes;
    match_e      s;
    logic [7:0]  b;
    int unsigned pos;
    base = expected_tokens.size();
    waiting = 0;
    collapse = c_mode[0];
    autole = c_mode[1];
    rs_bytes = autole ? 32'(LF_BYTE) : c_rs;
    rs_len = autole ? 1 : clamp_len(0);
    fs_len = clamp_len(3);
    ps_len = clamp_len(6);
    cm_len = clamp_len(9);
    if (fill < 4) begin
      win[fill] = din;
      fill++;
    end
    while (fill > 0 && !waiting) begin
      case (ph)
        PH_RECORD_START: begin
          cr_last = 0;
          cr_held = 0;
          s = sep_state(c_cm, cm_len, eod);
          if (s == ST_MATCH) begin
            void'(take_bytes(cm_len));
            ph = PH_COMMENT;
          end else if (s == ST_WAIT) begin
            waiting = 1;
          end else begin
            ph = collapse ? PH_PAIR_START : PH_BODY;
          end
        end
        PH_COMMENT: begin
          s = sep_state(rs_bytes, rs_len, eod);
          if (s == ST_MATCH) begin
            void'(take_bytes(rs_len));
            ph = PH_RECORD_START;
          end else if (s == ST_WAIT) begin
            waiting = 1;
          end else begin
            void'(take_bytes(1));
          end
        end
        PH_PAIR_START: begin
          s = sep_state(c_fs, fs_len, eod);
          if (s == ST_MATCH) begin
            cr_last = (take_bytes(fs_len) == CR_BYTE);
          end else if (s == ST_WAIT) begin
            waiting = 1;
          end else begin
            ph = PH_BODY;
          end
        end
        default: begin
          done = 0;
          s = sep_state(rs_bytes, rs_len, eod);
          if (s == ST_MATCH) begin
            void'(take_bytes(rs_len));
            close_record(autole ? (cr_last ? LE_CRLF : LE_LF) : LE_NONE);
            done = 1;
          end else if (s == ST_WAIT) begin
            waiting = 1;
            done = 1;
          end
          if (!done) begin
            s = sep_state(c_fs, fs_len, eod);
            if (s == ST_MATCH) begin
              pos = next_pos();
              flush_cr();
              cr_last = (take_bytes(fs_len) == CR_BYTE);
              push_token(TOK_PAIR_END, 8'h00, pos, (!key_seen || !kv_sep), LE_NONE);
              pairs = pos;
              clear_pair();
              ph = collapse ? PH_PAIR_START : PH_BODY;
              done = 1;
            end else if (s == ST_WAIT) begin
              waiting = 1;
              done = 1;
            end
          end
          if (!done && !kv_sep) begin
            s = sep_state(c_ps, ps_len, eod);
            if (s == ST_MATCH) begin
              flush_cr();
              cr_last = (take_bytes(ps_len) == CR_BYTE);
              kv_sep = 1;
              done = 1;
            end else if (s == ST_WAIT) begin
              waiting = 1;
              done = 1;
            end
          end
          if (!done) begin
            b = take_bytes(1);
            flush_cr();
            if (autole && b == CR_BYTE) cr_held = 1;
            else text_token(b);
            cr_last = (b == CR_BYTE);
          end
        end
      endcase
    end
    if (eod) begin
      if (ph == PH_PAIR_START || ph == PH_BODY) begin
        flush_cr();
        close_record(LE_NONE);
      end
      reset_parse();
    end
    if (expected_tokens.size() > base) expected_tokens[$].last = 1'b1;
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    err_count++;
  endtask

  // Driver.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct &&
          (!pending_bytes[0].hold ||
           (expected_tokens.size() == 0 && !(in_ch.valid && in_ch.ready)))) begin
        in_ch.valid <= 1'b1;
        in_ch.data_byte <= pending_bytes[0].b;
        in_ch.end_of_data <= pending_bytes[0].eod;
        void'(pending_bytes.pop_front());
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    out_ch.ready <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor: prediction on accepted bytes, checking on accepted tokens.
  always @(posedge clk_i) begin
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      predict_tokens(in_ch.data_byte, in_ch.end_of_data);
      bytes_sent++;
    end
  end

  always @(posedge clk_i) begin
    res_t e;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      tokens_checked++;
      if (expected_tokens.size() == 0) begin
        report_mismatch("token with no expectation");
      end else begin
        e = expected_tokens.pop_front();
        if (out_ch.token_kind != e.kind)
          report_mismatch($sformatf("token_kind %0d, expected %0d", out_ch.token_kind, e.kind));
        if (out_ch.text_byte != e.text_byte)
          report_mismatch($sformatf("text_byte %h, expected %h", out_ch.text_byte, e.text_byte));
        if (out_ch.pair_position != e.pos)
          report_mismatch($sformatf("pair_position %0d, expected %0d",
                                    out_ch.pair_position, e.pos));
        if (out_ch.use_position_key != e.use_pos)
          report_mismatch($sformatf("use_position_key %0d, expected %0d",
                                    out_ch.use_position_key, e.use_pos));
        if (out_ch.line_ending != e.le)
          report_mismatch($sformatf("line_ending %0d, expected %0d", out_ch.line_ending, e.le));
        if (out_ch.last_result != e.last)
          report_mismatch($sformatf("last_result %0d, expected %0d",
                                    out_ch.last_result, e.last));
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we_i ||
        !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= 20000) begin
      $display("Timeout after %0d cycles without a transaction", quiet_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic put(logic [7:0] b, logic eod = 1'b0, bit hold = 1'b0);
    byte_item_t it;
    it.b = b;
    it.eod = eod;
    it.hold = hold;
    pending_bytes.push_back(it);
  endtask

  task automatic put_sep(logic [31:0] bytes, int len);
    for (int i = 0; i < len; i++) put(bytes[8*i +: 8]);
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() > 0 || in_ch.valid || expected_tokens.size() > 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [31:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    case (idx)
      REG_RECORD_SEP: c_rs = data;
      REG_FIELD_SEP:  c_fs = data;
      REG_PAIR_SEP:   c_ps = data;
      REG_COMMENT:    c_cm = data;
      REG_SEP_LENS:   c_len = data[11:0];
      default:        c_mode = data[1:0];
    endcase
  endtask

  task automatic cfg_done();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [7:0] pick_text();
    case ($urandom_range(9))
      0, 1, 2: return 8'h61 + 8'($urandom_range(3));
      3, 4:    return 8'($urandom_range(255));
      5:       return CR_BYTE;
      6:       return LF_BYTE;
      7:       return c_fs[7:0];
      8:       return c_ps[7:0];
      default: return c_cm[7:0];
    endcase
  endfunction

  task automatic gen_record();
    int          npairs;
    logic [31:0] rs_bytes;
    int          rs_len;
    rs_bytes = c_mode[1] ? 32'(LF_BYTE) : c_rs;
    rs_len = c_mode[1] ? 1 : clamp_len(0);
    if ($urandom_range(7) == 0) begin
      put_sep(c_cm, clamp_len(9));
      repeat ($urandom_range(3)) put(pick_text());
      put_sep(rs_bytes, rs_len);
    end
    if (c_mode[0] && $urandom_range(3) == 0) put_sep(c_fs, clamp_len(3));
    npairs = $urandom_range(1, 4);
    for (int p = 0; p < npairs; p++) begin
      repeat ($urandom_range(3)) put(pick_text());
      if ($urandom_range(3) != 0) put_sep(c_ps, clamp_len(6));
      repeat ($urandom_range(3)) put(pick_text());
      if ($urandom_range(9) == 0) put(8'($urandom_range(255)));
      if (p + 1 < npairs || $urandom_range(4) == 0) begin
        put_sep(c_fs, clamp_len(3));
        if ($urandom_range(5) == 0) put_sep(c_fs, clamp_len(3));
      end
    end
    if (c_mode[1] && $urandom_range(2) == 0) put(CR_BYTE);
    put_sep(rs_bytes, rs_len);
  endtask

  task automatic gen_chunk(int target, bit with_hold);
    int start;
    start = pending_bytes.size();
    while (pending_bytes.size() - start < target) gen_record();
    if (with_hold) pending_bytes[start].hold = 1'b1;
    if ($urandom_range(1) == 0) pending_bytes[$].eod = 1'b1;
  endtask

  initial begin
    int chunk;
    string msg;
    in_ch.valid = 1'b0;
    in_ch.data_byte = 8'h00;
    in_ch.end_of_data = 1'b0;
    out_ch.ready = 1'b0;
    reset_parse();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Defaults: empty key, missing separator, empty pairs, NUL and 0xFF, end mid-record.
    msg = "a=1,=2,b,,\n";
    foreach (msg[i]) put(msg[i]);
    put(8'h00);
    put(8'hFF);
    put(8'h3D);
    put(8'h3D, 1'b1);
    put(8'h7A);
    put(LF_BYTE, 1'b1);
    put(8'h2C, 1'b1);
    put(8'h3D, 1'b0, 1'b1);
    put(LF_BYTE);
    wait_drained();

    chunk = 0;
    for (int phase_no = 0; phase_no < 4; phase_no++) begin
      case (phase_no)
        0: begin
          cfg_write(REG_RECORD_SEP, 32'h0000_7C7C);
          cfg_write(REG_FIELD_SEP, 32'h003B_3B3B);
          cfg_write(REG_PAIR_SEP, 32'h0000_003A);
          cfg_write(REG_COMMENT, 32'h0000_0023);
          cfg_write(REG_SEP_LENS, 32'(2 | (3 << 3) | (1 << 6) | (1 << 9)));
          cfg_write(REG_MODE, 32'd1);
        end
        1: begin
          cfg_write(REG_RECORD_SEP, 32'hFFFF_FFFF);
          cfg_write(REG_FIELD_SEP, 32'h0000_002C);
          cfg_write(REG_PAIR_SEP, 32'h0000_3D3D);
          cfg_write(REG_COMMENT, 32'h0000_2F2F);
          cfg_write(REG_SEP_LENS, 32'(7 | (1 << 3) | (2 << 6) | (2 << 9)));
          cfg_write(REG_MODE, 32'd2);
        end
        2: begin
          cfg_write(REG_FIELD_SEP, 32'h0000_0000);
          cfg_write(REG_PAIR_SEP, 32'hFFFF_FFFF);
          cfg_write(REG_COMMENT, 32'h2323_2323);
          cfg_write(REG_SEP_LENS, 32'h0000_0FFF);
          cfg_write(REG_MODE, 32'd3);
        end
        default: begin
          cfg_write(REG_RECORD_SEP, 32'h0000_000A);
          cfg_write(REG_SEP_LENS, 32'h0000_0000);
          cfg_write(REG_MODE, 32'd0);
        end
      endcase
      cfg_done();
      for (int k = 0; k < 2; k++) begin
        case (chunk % 4)
          0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
          1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
          2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
          default: begin send_idle_pct = 9; recv_stall_pct = 9; end
        endcase
        gen_chunk(20, chunk == 3);
        while (pending_bytes.size() > 0) @(posedge clk_i);
        chunk++;
      end
      wait_drained();
    end

    while (expected_tokens.size() > 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (expected_tokens.size() != 0) report_mismatch("expected tokens left over");
    $display("Sent %0d bytes and checked %0d tokens over five separator settings,",
             bytes_sent, tokens_checked);
    $display("covering comments, collapse, auto line endings and random stalls.");
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
